[sv/process_traffic_counter_unit_defines.svh]
// assertion macros shared by the rtl files
`ifndef PROCESS_TRAFFIC_COUNTER_UNIT_DEFINES_SVH
`define PROCESS_TRAFFIC_COUNTER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PTC_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PTC_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PTC_CHECK(lbl, prop, msg)
`define PTC_CHECK_NEXT(lbl, ante, cons, msg)
`endif
`endif

[sv/ptc_pkg.sv]
package ptc_pkg;
  localparam int PTC_OWNER_ENTRIES  = 1024;
  localparam int PTC_LINK_ENTRIES   = 1024;
  localparam int PTC_FILTER_ENTRIES = 256;
  localparam int PTC_ANCESTOR_HOPS  = 5;

  localparam logic [1:0] OP_PACKET = 2'd0;
  localparam logic [1:0] OP_LINK   = 2'd1;
  localparam logic [1:0] OP_FILTER = 2'd2;

  localparam logic [2:0] ST_COUNTED   = 3'd0;
  localparam logic [2:0] ST_FILTERED  = 3'd1;
  localparam logic [2:0] ST_NO_ID     = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_LINK_OK   = 3'd4;
  localparam logic [2:0] ST_LINK_FULL = 3'd5;
  localparam logic [2:0] ST_FILTER_WR = 3'd6;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [15:0] LEN_IP_HDR  = 16'd34;
  localparam logic [15:0] LEN_UDP_HDR = 16'd42;
  localparam logic [15:0] LEN_TCP_HDR = 16'd54;

  typedef struct packed {
    logic [63:0] rx_bytes;
    logic [63:0] tx_bytes;
    logic [63:0] rx_pkts;
    logic [63:0] tx_pkts;
    logic [31:0] tcp;
    logic [31:0] udp;
  } cnt_t;

  localparam int CNT_W = $bits(cnt_t);
endpackage

[sv/ptc_filter.sv]
module ptc_filter #(
  parameter int ENTRIES = ptc_pkg::PTC_FILTER_ENTRIES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] rd_idx,
  output logic       drop,
  input  logic       wr_en,
  input  logic [7:0] wr_idx,
  input  logic       wr_value
);
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [ENTRIES-1:0] present_r;
  logic               value_mem [ENTRIES];
  logic               rd_value_r;
  logic               rd_hit_r;
  logic               rd_in, wr_in;

  assign rd_in = ({1'b0, rd_idx} < 9'(ENTRIES));
  assign wr_in = ({1'b0, wr_idx} < 9'(ENTRIES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      rd_hit_r  <= 1'b0;
    end else begin
      if (wr_en && wr_in) present_r[wr_idx[AW-1:0]] <= 1'b1;
      rd_hit_r <= rd_in && present_r[rd_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_in) value_mem[wr_idx[AW-1:0]] <= wr_value;
    rd_value_r <= value_mem[rd_idx[AW-1:0]];
  end

  // entry present and written zero drops the packet
  assign drop = rd_hit_r && !rd_value_r;
endmodule

[sv/ptc_assoc.sv]
`include "process_traffic_counter_unit_defines.svh"
module ptc_assoc #(
  parameter int ENTRIES = ptc_pkg::PTC_LINK_ENTRIES,
  parameter int DW      = 32,
  localparam int AW     = $clog2(ENTRIES),
  localparam int FW     = $clog2(ENTRIES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_key,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic          wr_alloc,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_key,
  input  logic [DW-1:0] wr_data,
  output logic [FW-1:0] fill
);
  // rows are never freed, so rows below the fill count are the valid ones
  logic [31:0]   key_mem  [ENTRIES];
  logic [DW-1:0] data_mem [ENTRIES];
  logic [FW-1:0] fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (wr_en && wr_alloc) begin
      fill_r <= fill_r + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]  <= wr_key;
      data_mem[wr_addr] <= wr_data;
    end
    rd_key  <= key_mem[rd_addr];
    rd_data <= data_mem[rd_addr];
  end

  assign fill = fill_r;

  `PTC_CHECK(a_fill_bound, fill_r <= FW'(ENTRIES), "fill count beyond table depth")
  `PTC_CHECK_NEXT(a_fill_step, wr_en && wr_alloc, fill_r == $past(fill_r) + FW'(1), "fill count missed an allocation")
endmodule

[sv/ptc_alu.sv]
module ptc_alu (
  input  logic [63:0] add_a,
  input  logic [63:0] add_b,
  output logic [63:0] sum,
  input  logic [31:0] cmp_a,
  input  logic [31:0] cmp_b,
  output logic        eq
);
  // the one adder and key comparator shared by the add steps and all scans
  assign sum = add_a + add_b;
  assign eq  = (cmp_a == cmp_b);
endmodule

[sv/process_traffic_counter_unit.sv]
// per-owner packet and byte counter. an item is either a packet, a parent link record or an
// interface filter write; each gives exactly one result item. link and owner tables are
// scanned one stored row at a time, a read state then a compare state, through a single
// key comparator, and counters are updated by one shared 64-bit adder in three steps. a
// filter write is done at dispatch, a link record scans the stored links, and a counted
// packet scans the links for each hop walked and then the stored owners, so the link and owner scans
// set the rate. no input item is taken while one is in work; a finished result waits in
// the output register. tables start empty after reset with no clearing pass.
`include "process_traffic_counter_unit_defines.svh"
module process_traffic_counter_unit #(
  parameter int OWNER_ENTRIES  = ptc_pkg::PTC_OWNER_ENTRIES,
  parameter int LINK_ENTRIES   = ptc_pkg::PTC_LINK_ENTRIES,
  parameter int FILTER_ENTRIES = ptc_pkg::PTC_FILTER_ENTRIES,
  parameter int ANCESTOR_HOPS  = ptc_pkg::PTC_ANCESTOR_HOPS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_current_id,
  input  logic [31:0] in_child_id,
  input  logic [7:0]  in_if_index,
  input  logic        in_filter_enabled,
  input  logic [63:0] in_socket_cookie,
  input  logic        in_ingress,
  input  logic [15:0] in_packet_len,
  input  logic [15:0] in_captured_len,
  input  logic [15:0] in_ether_type,
  input  logic [7:0]  in_ip_protocol,
  input  logic [7:0]  in_tcp_flags,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_root_id,
  output logic [63:0] out_rx_bytes,
  output logic [63:0] out_tx_bytes,
  output logic [63:0] out_rx_pkts,
  output logic [63:0] out_tx_pkts,
  output logic [31:0] out_tcp_opens,
  output logic [31:0] out_udp_packets
);
  localparam int LAW = $clog2(LINK_ENTRIES);
  localparam int LFW = $clog2(LINK_ENTRIES + 1);
  localparam int OAW = $clog2(OWNER_ENTRIES);
  localparam int OFW = $clog2(OWNER_ENTRIES + 1);
  localparam int CW  = (LFW > OFW) ? LFW : OFW;
  localparam int HW  = $clog2(ANCESTOR_HOPS + 1);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_READ = 4'd2;
  localparam logic [3:0] S_CMP  = 4'd3;
  localparam logic [3:0] S_ADD0 = 4'd4;
  localparam logic [3:0] S_ADD1 = 4'd5;
  localparam logic [3:0] S_ADD2 = 4'd6;
  localparam logic [3:0] S_WB   = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  // what the current table scan is for
  localparam logic [1:0] M_LINK  = 2'd0;
  localparam logic [1:0] M_WALK  = 2'd1;
  localparam logic [1:0] M_OWNER = 2'd2;

  logic [3:0]  state_r, state_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [HW-1:0] hop_r, hop_nxt;
  logic [31:0] key_r, key_nxt;     // search key, also the root during the walk
  logic [31:0] id_r, id_nxt;       // owner id before the walk
  logic [OAW-1:0] row_r, row_nxt;
  logic        new_r, new_nxt;
  ptc_pkg::cnt_t cnt_r, cnt_nxt;
  logic [2:0]  res_r, res_nxt;

  // latched item
  logic [1:0]  op_r;
  logic [31:0] cur_r, child_r, cookie_r;
  logic [7:0]  ifx_r;
  logic        fen_r, ing_r, tcp_r, udp_r;
  logic [15:0] len_r;

  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [31:0] out_root_r;
  ptc_pkg::cnt_t out_cnt_r;

  logic        in_acc, ipv4, tcp_open, udp_hit;
  logic        drop, flt_we;
  logic [31:0] lk_rkey, lk_rdata, ow_rkey;
  logic [ptc_pkg::CNT_W-1:0] ow_rdata;
  logic [LFW-1:0] lk_fill;
  logic [OFW-1:0] ow_fill;
  logic        lk_we, lk_alloc, ow_we;
  logic [LAW-1:0] lk_waddr;
  logic [63:0] add_a, add_b, sum;
  logic        eq, scan_end;
  logic [31:0] owner_key;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // header classification done as the item comes in (fixed 20-byte ipv4 header)
  assign ipv4     = (in_captured_len >= ptc_pkg::LEN_IP_HDR) &&
                    (in_ether_type == ptc_pkg::ETYPE_IPV4);
  assign tcp_open = ipv4 && (in_ip_protocol == ptc_pkg::PROTO_TCP) &&
                    (in_captured_len >= ptc_pkg::LEN_TCP_HDR) &&
                    in_tcp_flags[1] && !in_tcp_flags[4];
  assign udp_hit  = ipv4 && (in_ip_protocol == ptc_pkg::PROTO_UDP) &&
                    (in_captured_len >= ptc_pkg::LEN_UDP_HDR);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= in_operation;
      cur_r    <= in_current_id;
      child_r  <= in_child_id;
      ifx_r    <= in_if_index;
      fen_r    <= in_filter_enabled;
      cookie_r <= in_socket_cookie[31:0];
      ing_r    <= in_ingress;
      len_r    <= in_packet_len;
      tcp_r    <= tcp_open;
      udp_r    <= udp_hit;
    end
  end

  ptc_filter #(.ENTRIES(FILTER_ENTRIES)) u_filter (
    .clk, .rst_n,
    .rd_idx(in_if_index), .drop,
    .wr_en(flt_we), .wr_idx(ifx_r), .wr_value(fen_r)
  );

  ptc_assoc #(.ENTRIES(LINK_ENTRIES), .DW(32)) u_links (
    .clk, .rst_n,
    .rd_addr(idx_r[LAW-1:0]), .rd_key(lk_rkey), .rd_data(lk_rdata),
    .wr_en(lk_we), .wr_alloc(lk_alloc), .wr_addr(lk_waddr),
    .wr_key(child_r), .wr_data(cur_r), .fill(lk_fill)
  );

  ptc_assoc #(.ENTRIES(OWNER_ENTRIES), .DW(ptc_pkg::CNT_W)) u_owners (
    .clk, .rst_n,
    .rd_addr(idx_r[OAW-1:0]), .rd_key(ow_rkey), .rd_data(ow_rdata),
    .wr_en(ow_we), .wr_alloc(new_r), .wr_addr(row_r),
    .wr_key(key_r), .wr_data(cnt_r), .fill(ow_fill)
  );

  ptc_alu u_alu (
    .add_a, .add_b, .sum,
    .cmp_a((mode_r == M_OWNER) ? ow_rkey : lk_rkey), .cmp_b(key_r), .eq
  );

  // end of the stored rows of the table being scanned
  assign scan_end  = (mode_r == M_OWNER) ? (idx_r == CW'(ow_fill)) : (idx_r == CW'(lk_fill));
  // a walk that lands on zero falls back to the original id
  assign owner_key = (key_r == 32'd0) ? id_r : key_r;

  // shared adder operands per update step
  always_comb begin
    add_a = '0;
    add_b = '0;
    unique case (state_r)
      S_ADD0: begin
        add_a = ing_r ? cnt_r.rx_bytes : cnt_r.tx_bytes;
        add_b = {48'd0, len_r};
      end
      S_ADD1: begin
        add_a = ing_r ? cnt_r.rx_pkts : cnt_r.tx_pkts;
        add_b = 64'd1;
      end
      S_ADD2: begin
        add_a = {32'd0, tcp_r ? cnt_r.tcp : cnt_r.udp};
        add_b = {63'd0, tcp_r | udp_r};
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    idx_nxt   = idx_r;
    hop_nxt   = hop_r;
    key_nxt   = key_r;
    id_nxt    = id_r;
    row_nxt   = row_r;
    new_nxt   = new_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    flt_we    = 1'b0;
    lk_we     = 1'b0;
    lk_alloc  = 1'b0;
    lk_waddr  = idx_r[LAW-1:0];
    ow_we     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_DISP;
      end
      S_DISP: begin
        cnt_nxt = '0;
        key_nxt = '0;
        idx_nxt = '0;
        hop_nxt = '0;
        unique case (op_r)
          ptc_pkg::OP_FILTER: begin
            flt_we    = 1'b1;
            res_nxt   = ptc_pkg::ST_FILTER_WR;
            state_nxt = S_OUT;
          end
          ptc_pkg::OP_LINK: begin
            key_nxt   = child_r;
            mode_nxt  = M_LINK;
            state_nxt = S_READ;
          end
          ptc_pkg::OP_PACKET: begin
            if (drop) begin
              res_nxt   = ptc_pkg::ST_FILTERED;
              state_nxt = S_OUT;
            end else if (cur_r == 32'd0 && cookie_r == 32'd0) begin
              res_nxt   = ptc_pkg::ST_NO_ID;
              state_nxt = S_OUT;
            end else begin
              id_nxt    = (cur_r != 32'd0) ? cur_r : cookie_r;
              key_nxt   = (cur_r != 32'd0) ? cur_r : cookie_r;
              mode_nxt  = M_WALK;
              state_nxt = S_READ;
            end
          end
          default: begin
            state_nxt = S_IDLE;   // unused operation gives no result
          end
        endcase
      end
      S_READ: begin
        if (!scan_end) begin
          state_nxt = S_CMP;
        end else begin
          unique case (mode_r)
            M_LINK: begin
              if (lk_fill == LFW'(LINK_ENTRIES)) begin
                res_nxt = ptc_pkg::ST_LINK_FULL;
              end else begin
                lk_we    = 1'b1;
                lk_alloc = 1'b1;
                lk_waddr = lk_fill[LAW-1:0];
                res_nxt  = ptc_pkg::ST_LINK_OK;
              end
              state_nxt = S_OUT;
            end
            M_WALK: begin
              key_nxt   = owner_key;
              idx_nxt   = '0;
              mode_nxt  = M_OWNER;
              state_nxt = S_READ;
            end
            default: begin
              if (ow_fill == OFW'(OWNER_ENTRIES)) begin
                res_nxt   = ptc_pkg::ST_FULL;
                state_nxt = S_OUT;
              end else begin
                row_nxt   = ow_fill[OAW-1:0];
                new_nxt   = 1'b1;
                state_nxt = S_ADD0;
              end
            end
          endcase
        end
      end
      S_CMP: begin
        if (!eq) begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_READ;
        end else begin
          unique case (mode_r)
            M_LINK: begin
              lk_we     = 1'b1;
              res_nxt   = ptc_pkg::ST_LINK_OK;
              state_nxt = S_OUT;
            end
            M_WALK: begin
              hop_nxt = hop_r + HW'(1);
              idx_nxt = '0;
              if (hop_r + HW'(1) == HW'(ANCESTOR_HOPS)) begin
                key_nxt  = (lk_rdata == 32'd0) ? id_r : lk_rdata;
                mode_nxt = M_OWNER;
              end else begin
                key_nxt  = lk_rdata;
              end
              state_nxt = S_READ;
            end
            default: begin
              row_nxt   = idx_r[OAW-1:0];
              new_nxt   = 1'b0;
              cnt_nxt   = ow_rdata;
              state_nxt = S_ADD0;
            end
          endcase
        end
      end
      S_ADD0: begin
        if (ing_r) cnt_nxt.rx_bytes = sum;
        else       cnt_nxt.tx_bytes = sum;
        state_nxt = S_ADD1;
      end
      S_ADD1: begin
        if (ing_r) cnt_nxt.rx_pkts = sum;
        else       cnt_nxt.tx_pkts = sum;
        state_nxt = S_ADD2;
      end
      S_ADD2: begin
        if (tcp_r) cnt_nxt.tcp = sum[31:0];
        else       cnt_nxt.udp = sum[31:0];
        state_nxt = S_WB;
      end
      S_WB: begin
        ow_we     = 1'b1;
        res_nxt   = ptc_pkg::ST_COUNTED;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= M_LINK;
      new_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      new_r   <= new_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    hop_r <= hop_nxt;
    key_r <= key_nxt;
    id_r  <= id_nxt;
    row_r <= row_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
  end

  // result register, loaded when the slot is free or being emptied
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
      out_status_r <= res_r;
      out_root_r   <= (res_r == ptc_pkg::ST_COUNTED || res_r == ptc_pkg::ST_FULL) ?
                      key_r : 32'd0;
      out_cnt_r    <= cnt_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_root_id     = out_root_r;
  assign out_rx_bytes    = out_cnt_r.rx_bytes;
  assign out_tx_bytes    = out_cnt_r.tx_bytes;
  assign out_rx_pkts     = out_cnt_r.rx_pkts;
  assign out_tx_pkts     = out_cnt_r.tx_pkts;
  assign out_tcp_opens   = out_cnt_r.tcp;
  assign out_udp_packets = out_cnt_r.udp;

  `PTC_CHECK_NEXT(a_accept_dispatch, in_acc, state_r == S_DISP, "accepted item not dispatched")
  `PTC_CHECK(a_status_range, !out_valid_r || out_status_r <= ptc_pkg::ST_FILTER_WR, "bad status")
  `PTC_CHECK(a_hop_bound, hop_r <= HW'(ANCESTOR_HOPS) || state_r <= S_DISP, "hop limit passed")
endmodule

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // the one operation code the package leaves out: accepted, never answered
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 12_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 600;
  localparam int RANDOM_ITEMS = 560;

  // one input item, field by field
  typedef struct {
    logic [1:0]  op;
    logic [31:0] cur;
    logic [31:0] child;
    logic [7:0]  ifx;
    logic        fen;
    logic [63:0] cookie;
    logic        ing;
    logic [15:0] len;
    logic [15:0] cap;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [7:0]  flags;
  } traffic_item_t;

  // one result item
  typedef struct {
    bit [2:0]  status;
    bit [31:0] root;
    bit [63:0] bin;
    bit [63:0] bout;
    bit [63:0] pin;
    bit [63:0] pout;
    bit [31:0] tcp;
    bit [31:0] udp;
  } tally_t;

  // directed row: typed rows carry their own expected result
  typedef struct {
    traffic_item_t item;
    bit            typed;
    tally_t        want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = '0;
  logic [31:0] in_current_id = '0;
  logic [31:0] in_child_id = '0;
  logic [7:0]  in_if_index = '0;
  logic        in_filter_enabled = 1'b0;
  logic [63:0] in_socket_cookie = '0;
  logic        in_ingress = 1'b0;
  logic [15:0] in_packet_len = '0;
  logic [15:0] in_captured_len = '0;
  logic [15:0] in_ether_type = '0;
  logic [7:0]  in_ip_protocol = '0;
  logic [7:0]  in_tcp_flags = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_root_id;
  logic [63:0] out_rx_bytes;
  logic [63:0] out_tx_bytes;
  logic [63:0] out_rx_pkts;
  logic [63:0] out_tx_pkts;
  logic [31:0] out_tcp_opens;
  logic [31:0] out_udp_packets;

  process_traffic_counter_unit dut (.*);

  always #6 clk = ~clk;

  // shadow copy of the filter, link and owner tables
  bit        flt_present [ptc_pkg::PTC_FILTER_ENTRIES];
  bit        flt_value   [ptc_pkg::PTC_FILTER_ENTRIES];
  bit        lnk_valid   [ptc_pkg::PTC_LINK_ENTRIES];
  bit [31:0] lnk_child   [ptc_pkg::PTC_LINK_ENTRIES];
  bit [31:0] lnk_parent  [ptc_pkg::PTC_LINK_ENTRIES];
  bit        own_valid   [ptc_pkg::PTC_OWNER_ENTRIES];
  bit [31:0] own_key     [ptc_pkg::PTC_OWNER_ENTRIES];
  bit [63:0] cnt_bin     [ptc_pkg::PTC_OWNER_ENTRIES];
  bit [63:0] cnt_bout    [ptc_pkg::PTC_OWNER_ENTRIES];
  bit [63:0] cnt_pin     [ptc_pkg::PTC_OWNER_ENTRIES];
  bit [63:0] cnt_pout    [ptc_pkg::PTC_OWNER_ENTRIES];
  bit [31:0] cnt_tcp     [ptc_pkg::PTC_OWNER_ENTRIES];
  bit [31:0] cnt_udp     [ptc_pkg::PTC_OWNER_ENTRIES];
  int        lnk_count;
  int        own_count;

  tally_t    tally_q[$];     // results still owed by the block, oldest first
  int        errors;
  int        burst_left;
  bit        hold_req;       // asks the receiver for one long hold-off
  longint    cycles;

  function automatic int find_link_row(bit [31:0] child);
    for (int i = 0; i < ptc_pkg::PTC_LINK_ENTRIES; i++)
      if (lnk_valid[i] && lnk_child[i] == child) return i;
    return -1;
  endfunction

  function automatic int find_owner_row(bit [31:0] key);
    for (int i = 0; i < ptc_pkg::PTC_OWNER_ENTRIES; i++)
      if (own_valid[i] && own_key[i] == key) return i;
    return -1;
  endfunction

  // applies one item to the shadow tables; returns 0 when no result is due
  function automatic bit account_item(traffic_item_t it, output tally_t t);
    int        row;
    bit [31:0] id;
    bit [31:0] root;
    t = '{default: '0};
    case (it.op)
      ptc_pkg::OP_LINK: begin
        row = find_link_row(it.child);
        if (row < 0)
          for (int i = 0; i < ptc_pkg::PTC_LINK_ENTRIES; i++)
            if (!lnk_valid[i]) begin
              row = i;
              break;
            end
        if (row < 0) begin
          t.status = ptc_pkg::ST_LINK_FULL;
        end else begin
          if (!lnk_valid[row]) lnk_count++;
          lnk_valid[row]  = 1'b1;
          lnk_child[row]  = it.child;
          lnk_parent[row] = it.cur;
          t.status = ptc_pkg::ST_LINK_OK;
        end
        return 1'b1;
      end
      ptc_pkg::OP_FILTER: begin
        flt_present[it.ifx] = 1'b1;
        flt_value[it.ifx]   = it.fen;
        t.status = ptc_pkg::ST_FILTER_WR;
        return 1'b1;
      end
      ptc_pkg::OP_PACKET: begin
        if (flt_present[it.ifx] && !flt_value[it.ifx]) begin
          t.status = ptc_pkg::ST_FILTERED;
          return 1'b1;
        end
        id = (it.cur != 0) ? it.cur : it.cookie[31:0];
        if (id == 0) begin
          t.status = ptc_pkg::ST_NO_ID;
          return 1'b1;
        end
        // walk up the parent links, bounded hop count
        root = id;
        for (int h = 0; h < ptc_pkg::PTC_ANCESTOR_HOPS; h++) begin
          row = find_link_row(root);
          if (row < 0) break;
          root = lnk_parent[row];
        end
        if (root == 0) root = id;
        row = find_owner_row(root);
        if (row < 0) begin
          for (int i = 0; i < ptc_pkg::PTC_OWNER_ENTRIES; i++)
            if (!own_valid[i]) begin
              row = i;
              break;
            end
          if (row < 0) begin
            t.status = ptc_pkg::ST_FULL;
            t.root   = root;
            return 1'b1;
          end
          own_count++;
          own_valid[row] = 1'b1;
          own_key[row]   = root;
          cnt_bin[row] = '0; cnt_bout[row] = '0;
          cnt_pin[row] = '0; cnt_pout[row] = '0;
          cnt_tcp[row] = '0; cnt_udp[row]  = '0;
        end
        if (it.ing) begin
          cnt_pin[row]++;
          cnt_bin[row] += it.len;
        end else begin
          cnt_pout[row]++;
          cnt_bout[row] += it.len;
        end
        // fixed 20-byte ipv4 header assumed
        if (it.etype == ptc_pkg::ETYPE_IPV4 && it.cap >= ptc_pkg::LEN_IP_HDR) begin
          if (it.proto == ptc_pkg::PROTO_TCP) begin
            if (it.cap >= ptc_pkg::LEN_TCP_HDR && it.flags[1] && !it.flags[4])
              cnt_tcp[row]++;
          end else if (it.proto == ptc_pkg::PROTO_UDP) begin
            if (it.cap >= ptc_pkg::LEN_UDP_HDR) cnt_udp[row]++;
          end
        end
        t = '{ptc_pkg::ST_COUNTED, root, cnt_bin[row], cnt_bout[row], cnt_pin[row],
              cnt_pout[row], cnt_tcp[row], cnt_udp[row]};
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic traffic_item_t mk(logic [1:0] op, logic [31:0] cur, logic [31:0] child,
                                       logic [7:0] ifx, logic fen, logic [63:0] cookie,
                                       logic ing, logic [15:0] len, logic [15:0] cap,
                                       logic [15:0] etype, logic [7:0] proto,
                                       logic [7:0] flags);
    mk = '{op, cur, child, ifx, fen, cookie, ing, len, cap, etype, proto, flags};
  endfunction

  function automatic tally_t tl(bit [2:0] st, bit [31:0] root, bit [63:0] bin, bit [63:0] pin,
                                bit [31:0] udp);
    tl = '{st, root, bin, 64'd0, pin, 64'd0, 32'd0, udp};
  endfunction

  function automatic logic [31:0] pool_id();
    pool_id = $urandom_range(1, 40);
  endfunction

  // random item, shaped toward ids that share links and owners
  function automatic traffic_item_t rand_item();
    traffic_item_t it;
    int            k;
    logic [15:0]   edge_lens [9];
    edge_lens = '{16'd0, 16'd13, 16'd14, 16'd33, 16'd34, 16'd41, 16'd42, 16'd53, 16'd54};
    it = mk(2'($urandom), $urandom, $urandom, 8'($urandom), 1'($urandom),
            {$urandom, $urandom}, 1'($urandom), 16'($urandom), 16'($urandom),
            16'($urandom), 8'($urandom), 8'($urandom));
    k = $urandom_range(0, 99);
    if (k < 3) begin
      it.op = OP_UNUSED;
    end else if (k < 18) begin
      it.op = ptc_pkg::OP_LINK;
      if ($urandom_range(0, 7) != 0) it.child = pool_id();
      case ($urandom_range(0, 7))
        0: it.cur = '0;
        1: ;
        default: it.cur = pool_id();
      endcase
    end else if (k < 25) begin
      it.op = ptc_pkg::OP_FILTER;
      if ($urandom_range(0, 3) != 0) it.ifx = 8'($urandom_range(0, 15));
      it.fen = ($urandom_range(0, 9) < 7);
    end else begin
      it.op = ptc_pkg::OP_PACKET;
      if ($urandom_range(0, 4) != 0) it.ifx = 8'($urandom_range(0, 15));
      case ($urandom_range(0, 9))
        0, 1: begin
          it.cur = '0;
          case ($urandom_range(0, 2))
            0: it.cookie = '0;
            1: it.cookie[31:0] = '0;
            default: it.cookie[31:0] = pool_id();
          endcase
        end
        2: ;
        default: it.cur = pool_id();
      endcase
      if ($urandom_range(0, 9) != 0) it.cap = edge_lens[$urandom_range(0, 8)];
      if ($urandom_range(0, 9) < 8) it.etype = ptc_pkg::ETYPE_IPV4;
      case ($urandom_range(0, 4))
        0, 1: it.proto = ptc_pkg::PROTO_TCP;
        2, 3: it.proto = ptc_pkg::PROTO_UDP;
        default: ;
      endcase
      if ($urandom_range(0, 1) != 0) it.flags = (it.flags & 8'hef) | 8'h02;
    end
    return it;
  endfunction

  // drives one item, waits for the handshake and books the expected result
  task automatic offer(traffic_item_t it, bit typed = 1'b0, tally_t want = '{default: '0});
    tally_t t;
    bit     due;
    int     gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_operation      <= it.op;
    in_current_id     <= it.cur;
    in_child_id       <= it.child;
    in_if_index       <= it.ifx;
    in_filter_enabled <= it.fen;
    in_socket_cookie  <= it.cookie;
    in_ingress        <= it.ing;
    in_packet_len     <= it.len;
    in_captured_len   <= it.cap;
    in_ether_type     <= it.etype;
    in_ip_protocol    <= it.proto;
    in_tcp_flags      <= it.flags;
    in_valid          <= 1'b1;
    do @(posedge clk); while (!in_ready);
    due = account_item(it, t);
    if (due) tally_q.push_back(typed ? want : t);
  endtask

  // sender stops offering until every owed result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (tally_q.size() != 0);
  endtask

  // result side: check, then pick the next ready value
  initial begin
    int          rx_mode;
    int          rx_tick;
    int          hold_left;
    tally_t      want;
    logic [63:0] got_w [8];
    logic [63:0] want_w [8];
    string       names [8];
    names = '{"status", "root_id", "rx_bytes", "tx_bytes", "rx_pkts", "tx_pkts",
              "tcp_opens", "udp_packets"};
    forever begin
      @(posedge clk);
      rx_tick++;
      if (out_valid && out_ready) begin
        if (tally_q.size() == 0) begin
          $display("%0t: result item with nothing expected, status %0d", $realtime,
                   out_status);
          errors++;
        end else begin
          want = tally_q.pop_front();
          got_w = '{out_status, out_root_id, out_rx_bytes, out_tx_bytes, out_rx_pkts,
                    out_tx_pkts, out_tcp_opens, out_udp_packets};
          want_w = '{want.status, want.root, want.bin, want.bout, want.pin, want.pout,
                     want.tcp, want.udp};
          for (int f = 0; f < 8; f++)
            if (got_w[f] !== want_w[f]) begin
              $display("%0t: %s expected %0h actual %0h", $realtime, names[f], want_w[f],
                       got_w[f]);
              errors++;
            end
        end
      end
      if (rx_tick % 150 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left == 0 && hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        // long hold-off: block fills up and backs up the input side
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (rx_tick % 7 >= 3);
        endcase
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    dir_row_t      rows[$];
    traffic_item_t it;
    int            n;
    // directed rows; ids 7, 9 and 11 form a small link chain
    rows.push_back('{mk(ptc_pkg::OP_PACKET, 0, 0, 8'd3, 0, 0, 1, 16'd100, 16'd60,
                        ptc_pkg::ETYPE_IPV4, ptc_pkg::PROTO_UDP, 0), 1,
                     tl(ptc_pkg::ST_NO_ID, 0, 0, 0, 0)});
    rows.push_back('{mk(OP_UNUSED, '1, '1, '1, 1, '1, 1, '1, '1, '1, '1, '1), 0,
                     '{default: '0}});
    rows.push_back('{mk(ptc_pkg::OP_FILTER, 0, 0, 8'd255, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                     tl(ptc_pkg::ST_FILTER_WR, 0, 0, 0, 0)});
    rows.push_back('{mk(ptc_pkg::OP_PACKET, 5, 0, 8'd255, 0, 0, 1, 16'd64, 16'd60,
                        ptc_pkg::ETYPE_IPV4, ptc_pkg::PROTO_TCP, 8'h02), 1,
                     tl(ptc_pkg::ST_FILTERED, 0, 0, 0, 0)});
    rows.push_back('{mk(ptc_pkg::OP_FILTER, 0, 0, 8'd255, 1, 0, 0, 0, 0, 0, 0, 0), 1,
                     tl(ptc_pkg::ST_FILTER_WR, 0, 0, 0, 0)});
    rows.push_back('{mk(ptc_pkg::OP_PACKET, '1, '1, 8'd255, 1, '1, 1, '1, '1,
                        ptc_pkg::ETYPE_IPV4, ptc_pkg::PROTO_UDP, '1), 1,
                     tl(ptc_pkg::ST_COUNTED, '1, 64'hffff, 64'd1, 32'd1)});
    rows.push_back('{mk(ptc_pkg::OP_PACKET, 0, 0, 8'd1, 0, 64'hffffffff_00000000, 0, 1, 0,
                        0, 0, 0), 1, tl(ptc_pkg::ST_NO_ID, 0, 0, 0, 0)});
    rows.push_back('{mk(ptc_pkg::OP_PACKET, 0, 0, 8'd1, 0, 64'hffffffff_12345678, 0, 0, 0,
                        0, 0, 0), 0, '{default: '0}});
    rows.push_back('{mk(ptc_pkg::OP_LINK, 9, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                     tl(ptc_pkg::ST_LINK_OK, 0, 0, 0, 0)});
    rows.push_back('{mk(ptc_pkg::OP_LINK, 0, 9, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                     tl(ptc_pkg::ST_LINK_OK, 0, 0, 0, 0)});
    // chain ends in a zero parent, so the original id is charged
    rows.push_back('{mk(ptc_pkg::OP_PACKET, 7, 0, 0, 0, 0, 1, 16'd40, 0, 0, 0, 0), 0,
                     '{default: '0}});
    // overwrite of an existing link
    rows.push_back('{mk(ptc_pkg::OP_LINK, 11, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                     tl(ptc_pkg::ST_LINK_OK, 0, 0, 0, 0)});
    // header length edges for tcp open and udp
    rows.push_back('{mk(ptc_pkg::OP_PACKET, 7, 0, 0, 0, 0, 0, 16'd60, 16'd54,
                        ptc_pkg::ETYPE_IPV4, ptc_pkg::PROTO_TCP, 8'h02), 0,
                     '{default: '0}});
    rows.push_back('{mk(ptc_pkg::OP_PACKET, 7, 0, 0, 0, 0, 0, 16'd60, 16'd53,
                        ptc_pkg::ETYPE_IPV4, ptc_pkg::PROTO_TCP, 8'h02), 0,
                     '{default: '0}});
    rows.push_back('{mk(ptc_pkg::OP_PACKET, 7, 0, 0, 0, 0, 1, 16'd60, 16'd54,
                        ptc_pkg::ETYPE_IPV4, ptc_pkg::PROTO_TCP, 8'h12), 0,
                     '{default: '0}});
    rows.push_back('{mk(ptc_pkg::OP_PACKET, 7, 0, 0, 0, 0, 1, 16'd60, 16'd42,
                        ptc_pkg::ETYPE_IPV4, ptc_pkg::PROTO_UDP, 0), 0, '{default: '0}});
    rows.push_back('{mk(ptc_pkg::OP_PACKET, 7, 0, 0, 0, 0, 1, 16'd60, 16'd41,
                        ptc_pkg::ETYPE_IPV4, ptc_pkg::PROTO_UDP, 0), 0, '{default: '0}});
    rows.push_back('{mk(ptc_pkg::OP_PACKET, 7, 0, 0, 0, 0, 0, 16'd60, 16'd60,
                        ptc_pkg::ETYPE_IPV4, 8'd1, 0), 0, '{default: '0}});
    rows.push_back('{mk(ptc_pkg::OP_PACKET, 7, 0, 0, 0, 0, 0, 16'd60, 16'd60, 16'h86dd,
                        ptc_pkg::PROTO_UDP, 0), 0, '{default: '0}});
    // owner taken from the cookie, then resolved through a link
    rows.push_back('{mk(ptc_pkg::OP_PACKET, 0, 0, 0, 0, 64'h7, 1, 16'd9, 0, 0, 0, 0), 0,
                     '{default: '0}});
    rows.push_back('{mk(ptc_pkg::OP_FILTER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                     tl(ptc_pkg::ST_FILTER_WR, 0, 0, 0, 0)});
    rows.push_back('{mk(ptc_pkg::OP_PACKET, 7, 0, 0, 0, 0, 1, 16'd9, 0, 0, 0, 0), 1,
                     tl(ptc_pkg::ST_FILTERED, 0, 0, 0, 0)});
    rows.push_back('{mk(ptc_pkg::OP_FILTER, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0), 1,
                     tl(ptc_pkg::ST_FILTER_WR, 0, 0, 0, 0)});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[r]) offer(rows[r].item, rows[r].typed, rows[r].want);
    wait_drained();

    // random mix; receiver starts with a long hold-off while items keep coming
    hold_req = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) offer(rand_item());
    wait_drained();

    // fill the owner table with fresh ids, then push past it
    offer(mk(ptc_pkg::OP_FILTER, 0, 0, 8'd200, 1, 0, 0, 0, 0, 0, 0, 0));
    n = 0;
    while (own_count < ptc_pkg::PTC_OWNER_ENTRIES) begin
      it = rand_item();
      it.op  = ptc_pkg::OP_PACKET;
      it.ifx = 8'd200;
      it.cur = 32'ha000_0000 + n;
      offer(it);
      n++;
    end
    for (int i = 0; i < 20; i++) begin
      it = rand_item();
      it.op  = ptc_pkg::OP_PACKET;
      it.ifx = 8'd200;
      it.cur = (i % 2 == 0) ? 32'hb000_0000 + i : pool_id();
      offer(it);
    end
    wait_drained();

    // fill the link table, then overwrite and overflow it
    n = 0;
    while (lnk_count < ptc_pkg::PTC_LINK_ENTRIES) begin
      offer(mk(ptc_pkg::OP_LINK, pool_id(), 32'hc000_0000 + n, 8'($urandom), 1'($urandom),
               {$urandom, $urandom}, 1'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 8'($urandom), 8'($urandom)));
      n++;
    end
    for (int i = 0; i < 12; i++)
      offer(mk(ptc_pkg::OP_LINK, $urandom,
               (i % 2 == 0) ? 32'hc000_0000 + i : 32'hd000_0000 + i,
               0, 0, 0, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 4; i++) begin
      it = rand_item();
      it.op  = ptc_pkg::OP_PACKET;
      it.ifx = 8'd200;
      it.cur = (i < 2) ? 32'hc000_0000 + i : pool_id();
      offer(it);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
